// ===== hdl/lpr_pkg.sv =====
// Package for the literal priority reorder block.
// Holds the controller state type, the command/status structs and constants.
// Depends on nothing.
package lpr_pkg;
	localparam int unsigned STORE_DEPTH = 32;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned CNT_W = 6;
	localparam logic [15:0] LITNR_LIMIT = 16'd100;
	localparam logic [CNT_W-1:0] MIN_TAIL = 6'd2;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK_RD,
		ST_CHECK,
		ST_SCAN,
		ST_SHIFT,
		ST_PART,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;        // store the input item
		logic clr;         // clear count and overflow
		logic chk_rd;      // read entry at order_list[2]
		logic scan_init;   // start scan of slot i
		logic scan_step;   // compare entry j with best
		logic shift_step;  // shift one entry toward best
		logic next_slot;   // advance i
		logic part_init;   // start pass two
		logic part_step;   // one element of pass two
		logic emit_init;   // start output
		logic emit_step;   // one result taken
	} cmd_t;

	typedef struct packed {
		logic       do_reorder;
		logic       scan_done;
		logic       shift_done;
		logic       slots_done;
		logic       part_done;
		logic       emit_done;
		logic       empty;
	} stat_t;
endpackage

// ===== hdl/lpr_ctrl.sv =====
// Controller state machine of the literal priority reorder block.
// Depends on lpr_pkg for the state type and command/status structs.
module lpr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	input  logic            out_ready,
	input  lpr_pkg::stat_t  stat,
	output logic            in_ready,
	output logic            out_valid,
	output lpr_pkg::cmd_t   cmd
);
	lpr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lpr_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lpr_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_d = lpr_pkg::ST_CHECK_RD;
				end
			end
			lpr_pkg::ST_CHECK_RD: begin
				if (stat.empty) begin
					cmd.clr = 1'b1;
					state_d = lpr_pkg::ST_LOAD;
				end else begin
					cmd.chk_rd = 1'b1;
					state_d = lpr_pkg::ST_CHECK;
				end
			end
			lpr_pkg::ST_CHECK: begin
				if (stat.do_reorder) begin
					cmd.scan_init = 1'b1;
					state_d = lpr_pkg::ST_SCAN;
				end else begin
					cmd.emit_init = 1'b1;
					state_d = lpr_pkg::ST_EMIT;
				end
			end
			lpr_pkg::ST_SCAN: begin
				if (stat.slots_done) begin
					cmd.part_init = 1'b1;
					state_d = lpr_pkg::ST_PART;
				end else if (stat.scan_done) begin
					state_d = lpr_pkg::ST_SHIFT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			lpr_pkg::ST_SHIFT: begin
				if (stat.shift_done) begin
					cmd.next_slot = 1'b1;
					state_d = lpr_pkg::ST_SCAN;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			lpr_pkg::ST_PART: begin
				if (stat.part_done) begin
					cmd.emit_init = 1'b1;
					state_d = lpr_pkg::ST_EMIT;
				end else begin
					cmd.part_step = 1'b1;
				end
			end
			lpr_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit_step = 1'b1;
					if (stat.emit_done) begin
						cmd.clr = 1'b1;
						state_d = lpr_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = lpr_pkg::ST_LOAD;
		endcase
	end
endmodule

// ===== hdl/lpr_datapath.sv =====
// Datapath of the literal priority reorder block: literal stores, order list,
// selection scan, shift and three-way partition. Depends on lpr_pkg.
module lpr_datapath #(
	parameter int unsigned CAP = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           builtin_symbol_count,
	input  logic [15:0]           symbol,
	input  logic [15:0]           literal_number,
	input  logic [15:0]           complexity,
	input  logic                  subgoal_mark,
	input  lpr_pkg::cmd_t         cmd,
	output lpr_pkg::stat_t        stat,
	output logic [lpr_pkg::IDX_W-1:0] position,
	output logic                  overflow,
	output logic                  last_res
);
	localparam int unsigned IW = lpr_pkg::IDX_W;
	localparam int unsigned CW = lpr_pkg::CNT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAP);

	logic        bi_q   [lpr_pkg::STORE_DEPTH];
	logic [15:0] num_q  [lpr_pkg::STORE_DEPTH];
	logic [15:0] cx_q   [lpr_pkg::STORE_DEPTH];
	logic        mk_q   [lpr_pkg::STORE_DEPTH];
	logic [IW-1:0] ord_q [lpr_pkg::STORE_DEPTH];
	logic [IW-1:0] tmp_q [lpr_pkg::STORE_DEPTH];

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] i_q, j_q, best_q, k_q, w_q;
	logic [1:0]    grp_q;
	logic          chk_q;

	// Entry under test and current best.
	logic [IW-1:0] e, b;
	logic          beats, sel_ok;
	logic          pe_mk, pe_bi, take;

	assign e = ord_q[j_q[IW-1:0]];
	assign b = ord_q[best_q[IW-1:0]];

	always_comb begin
		if (bi_q[e] || bi_q[b]) begin
			beats = (bi_q[e] && bi_q[b]) ? (num_q[e] < num_q[b]) : bi_q[e];
		end else begin
			beats = cx_q[e] > cx_q[b];
		end
		sel_ok = !mk_q[e] && beats;
	end

	// Pass two: element at slot j, group grp (0 unmarked, 1 marked builtin, 2 marked other).
	always_comb begin
		pe_mk = mk_q[e];
		pe_bi = bi_q[e];
		case (grp_q)
			2'd0: take = !pe_mk;
			2'd1: take = pe_mk && pe_bi;
			default: take = pe_mk && !pe_bi;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (cnt_q < CAP_C) cnt_q <= cnt_q + 1'b1;
			else ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < CAP_C) begin
			bi_q[cnt_q[IW-1:0]]  <= symbol < builtin_symbol_count;
			num_q[cnt_q[IW-1:0]] <= literal_number;
			cx_q[cnt_q[IW-1:0]]  <= complexity;
			mk_q[cnt_q[IW-1:0]]  <= subgoal_mark;
			ord_q[cnt_q[IW-1:0]] <= cnt_q[IW-1:0];
		end
		if (cmd.chk_rd) chk_q <= num_q[ord_q[2]] < lpr_pkg::LITNR_LIMIT;
		if (cmd.scan_init) begin
			i_q <= CW'(1);
			j_q <= CW'(2);
			best_q <= CW'(1);
		end
		if (cmd.scan_step) begin
			if (sel_ok) best_q <= j_q;
			j_q <= j_q + 1'b1;
		end
		if (cmd.shift_step) begin
			// Rotate the winner down to slot i one swap at a time.
			ord_q[best_q[IW-1:0]] <= ord_q[best_q[IW-1:0] - 1'b1];
			ord_q[best_q[IW-1:0] - 1'b1] <= ord_q[best_q[IW-1:0]];
			best_q <= best_q - 1'b1;
		end
		if (cmd.next_slot) begin
			i_q <= i_q + 1'b1;
			j_q <= i_q + CW'(2);
			best_q <= i_q + 1'b1;
		end
		if (cmd.part_init) begin
			j_q <= CW'(1);
			k_q <= CW'(1);
			grp_q <= 2'd0;
		end
		if (cmd.part_step) begin
			if (take) begin
				tmp_q[k_q[IW-1:0]] <= e;
				k_q <= k_q + 1'b1;
			end
			if (j_q + 1'b1 >= cnt_q) begin
				j_q <= CW'(1);
				grp_q <= grp_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
		if (cmd.emit_init) begin
			w_q <= '0;
			// Slot 0 of the copy keeps the head.
			tmp_q[0] <= ord_q[0];
			if (!stat.do_reorder) begin
				for (int unsigned x = 1; x < lpr_pkg::STORE_DEPTH; x++) tmp_q[x] <= ord_q[x];
			end
		end
		if (cmd.emit_step) w_q <= w_q + 1'b1;
	end

	always_comb begin
		stat = '0;
		stat.empty      = cnt_q == '0;
		stat.do_reorder = chk_q && (cnt_q > lpr_pkg::MIN_TAIL);
		stat.scan_done  = j_q >= cnt_q;
		stat.shift_done = best_q == i_q;
		stat.slots_done = i_q + 1'b1 >= cnt_q;
		stat.part_done  = grp_q == 2'd3;
		stat.emit_done  = w_q + 1'b1 >= cnt_q;
	end

	assign position = tmp_q[w_q[IW-1:0]];
	assign overflow = ovf_q;
	assign last_res = stat.emit_done;
endmodule

// ===== hdl/literal_priority_reorder.sv =====
// Literal priority reorder: loads a clause and emits its load positions in priority order.
// Flow: literals are stored as they arrive; after the last, a check of the third entry's
// literal number and of the count decides whether sorting runs: a selection scan with shift
// steps, then a three-way partition pass. Then one result per cycle while out_ready is high.
// Throughput: one clause at a time, set by the single compare unit of the scan loop.
// Reset: arst_n clears count, overflow flag, state and config. Uses lpr_ctrl and lpr_datapath.
module literal_priority_reorder #(
	parameter int unsigned MAX_LITERALS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write: the built-in symbol count.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Input literal channel. A transfer stores one literal while the store has room; else it sets overflow.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] symbol,
	input  logic [15:0] literal_number,
	input  logic [15:0] complexity,
	input  logic        subgoal_mark,
	input  logic        last,
	// Result channel. Each transfer moves one position.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  position,
	output logic        overflow,
	output logic        last_res
);
	// Capacity is limited to the 32-entry store.
	localparam int unsigned CAP = (MAX_LITERALS < 32) ? MAX_LITERALS : 32;

	logic [15:0] builtin_cnt_q;
	lpr_pkg::cmd_t  cmd;
	lpr_pkg::stat_t stat;

	// The user must write the register only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) builtin_cnt_q <= '0;
		else if (cfg_we) builtin_cnt_q <= cfg_wdata;
	end

	lpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last),
		.out_ready(out_ready), .stat(stat), .in_ready(in_ready),
		.out_valid(out_valid), .cmd(cmd)
	);

	lpr_datapath #(.CAP(CAP)) u_dp (
		.clk(clk), .arst_n(arst_n), .builtin_symbol_count(builtin_cnt_q),
		.symbol(symbol), .literal_number(literal_number), .complexity(complexity),
		.subgoal_mark(subgoal_mark), .cmd(cmd), .stat(stat),
		.position(position), .overflow(overflow), .last_res(last_res)
	);
endmodule

// ===== hdl/lpr_checker.sv =====
// Port-level checker for the literal priority reorder block, and its bind.
// Depends only on the top level's ports.
module lpr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic last_res,
	input logic overflow
);
	// Input and output never run at once.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready with out_valid");
	// Results stay until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out_valid dropped");
	// After the final result, inputs are taken again.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_res |=> in_ready) else $error("no return to load");
	// Overflow is constant within one clause output.
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && !$past(last_res) |-> $stable(overflow))
		else $error("overflow changed");
endmodule

bind literal_priority_reorder lpr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .last_res(last_res), .overflow(overflow)
);
